// ----- rtl/core/pwcf_pkg.sv -----
// shared types and constants for the pulse width capture block
package pwcf_pkg;

  localparam int unsigned VALUE_W   = 17;
  localparam int unsigned LIMIT_W   = 12;
  localparam int unsigned MIN_W     = 16;
  localparam int unsigned TALLY_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] SPACE_LIMIT_RST = 12'd3000;
  localparam logic [LIMIT_W-1:0] QUIET_TICKS_RST = 12'd50;
  localparam logic [MIN_W-1:0]   MIN_PULSE_RST   = 16'd10;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_READ_WIDTH = 3'd1,
    CMD_READ_LEVEL = 3'd2,
    CMD_POP        = 3'd3,
    CMD_READ_COUNT = 3'd4,
    CMD_READ_COPY  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 2'd0,
    REG_SPACE_LIMIT = 2'd1,
    REG_QUIET_TICKS = 2'd2,
    REG_MIN_PULSE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               enable;
    logic [LIMIT_W-1:0] space_limit;
    logic [LIMIT_W-1:0] quiet_ticks;
    logic [MIN_W-1:0]   min_pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic               push;
    logic [VALUE_W-1:0] value;
  } ring_push_t;

endpackage

// ----- rtl/core/pwcf_meas.sv -----
// high/low time counters, burst tally and the count/width read registers
module pwcf_meas #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  pwcf_pkg::cmd_t                cmd,
  input  logic                          line_level,
  input  pwcf_pkg::cfg_t                cfg,
  output logic [pwcf_pkg::VALUE_W-1:0]  result,
  output pwcf_pkg::ring_push_t          push
);

  logic                             line_now_r, line_now_nxt;
  logic [COUNT_WIDTH-1:0]           high_time_r, high_time_nxt;
  logic [pwcf_pkg::LIMIT_W-1:0]     low_time_r, low_time_nxt;
  logic [pwcf_pkg::TALLY_W-1:0]     tally_r, tally_nxt;
  logic [COUNT_WIDTH-1:0]           last_width_r, last_width_nxt;
  logic [pwcf_pkg::TALLY_W-1:0]     count_r, count_nxt;
  logic [pwcf_pkg::TALLY_W-1:0]     copy_r, copy_nxt;

  logic [COUNT_WIDTH-1:0]           ht1;
  logic [pwcf_pkg::LIMIT_W-1:0]     lt1;
  logic [pwcf_pkg::TALLY_W-1:0]     tally1;

  // counter update for one tick, then quiet / edge checks in order
  always_comb begin
    line_now_nxt   = line_now_r;
    high_time_nxt  = high_time_r;
    low_time_nxt   = low_time_r;
    tally_nxt      = tally_r;
    last_width_nxt = last_width_r;
    count_nxt      = count_r;
    copy_nxt       = copy_r;
    push           = '0;
    result         = '0;
    ht1            = high_time_r;
    lt1            = low_time_r;
    tally1         = tally_r;
    unique case (cmd)
      pwcf_pkg::CMD_TICK: begin
        if (!line_level && high_time_r != '0) begin
          ht1 = high_time_r;
        end else if (line_level && !(&high_time_r)) begin
          ht1 = high_time_r + 1'b1;
        end
        if (!line_level && low_time_r < cfg.space_limit) begin
          lt1 = low_time_r + 1'b1;
        end
        if (lt1 > cfg.quiet_ticks && tally_r != '0) begin
          tally1 = '0;
        end
      end
      pwcf_pkg::CMD_READ_WIDTH: result = pwcf_pkg::VALUE_W'(last_width_r);
      pwcf_pkg::CMD_READ_LEVEL: result = pwcf_pkg::VALUE_W'(line_now_r);
      pwcf_pkg::CMD_READ_COUNT: result = pwcf_pkg::VALUE_W'(count_r);
      pwcf_pkg::CMD_READ_COPY:  result = pwcf_pkg::VALUE_W'(copy_r);
      default: ;
    endcase

    if (accept) begin
      unique case (cmd)
        pwcf_pkg::CMD_TICK: begin
          line_now_nxt = line_level;
          if (cfg.enable) begin
            high_time_nxt = ht1;
            low_time_nxt  = lt1;
            tally_nxt     = tally1;
            if (lt1 > cfg.quiet_ticks && tally_r != '0) begin
              count_nxt = tally_r;
              copy_nxt  = tally_r;
            end
            // falling edge closes a high period
            if (!line_level && ht1 != '0) begin
              if (32'(ht1) > 32'(cfg.min_pulse_ticks) && !(&tally1)) begin
                tally_nxt = tally1 + 1'b1;
              end
              last_width_nxt = ht1;
              high_time_nxt  = '0;
              push.push      = 1'b1;
              push.value     = pwcf_pkg::VALUE_W'(ht1);
            end
            // rising edge closes a low period, stored negated
            if (line_level && lt1 != '0) begin
              low_time_nxt = '0;
              push.push    = 1'b1;
              push.value   = pwcf_pkg::VALUE_W'(0) - pwcf_pkg::VALUE_W'(lt1);
            end
          end
        end
        pwcf_pkg::CMD_READ_WIDTH: last_width_nxt = '0;
        pwcf_pkg::CMD_READ_COUNT: count_nxt = '0;
        pwcf_pkg::CMD_READ_COPY:  copy_nxt = '0;
        pwcf_pkg::CMD_CLEAR: begin
          last_width_nxt = '0;
          count_nxt      = '0;
          copy_nxt       = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_now_r   <= 1'b0;
      high_time_r  <= '0;
      low_time_r   <= '0;
      tally_r      <= '0;
      last_width_r <= '0;
      count_r      <= '0;
      copy_r       <= '0;
    end else begin
      line_now_r   <= line_now_nxt;
      high_time_r  <= high_time_nxt;
      low_time_r   <= low_time_nxt;
      tally_r      <= tally_nxt;
      last_width_r <= last_width_nxt;
      count_r      <= count_nxt;
      copy_r       <= copy_nxt;
    end
  end

endmodule

// ----- rtl/core/pwcf_ring.sv -----
// overwrite-oldest width ring with registered pop read
module pwcf_ring #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  pwcf_pkg::cmd_t                cmd,
  input  pwcf_pkg::ring_push_t          push,
  output logic [pwcf_pkg::VALUE_W-1:0]  pop_value
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);

  logic [pwcf_pkg::VALUE_W-1:0] mem [RING_DEPTH];
  logic [IDX_W-1:0]             wr_r, wr_nxt;
  logic [IDX_W-1:0]             rd_r, rd_nxt;
  logic [IDX_W-1:0]             wr_inc, rd_inc;
  logic [pwcf_pkg::VALUE_W-1:0] rd_data_r;
  logic                         pop_hit_r;
  logic                         pop_hit;
  logic                         do_push;
  logic                         do_pop;

  assign wr_inc  = (wr_r == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc  = (rd_r == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_r + 1'b1;
  assign do_push = accept && push.push;
  assign do_pop  = accept && (cmd == pwcf_pkg::CMD_POP);
  assign pop_hit = rd_r != wr_r;

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (do_push) begin
      wr_nxt = wr_inc;
      // full: drop the oldest entry
      if (wr_inc == rd_r) begin
        rd_nxt = rd_inc;
      end
    end else if (do_pop && pop_hit) begin
      rd_nxt = rd_inc;
    end else if (accept && cmd == pwcf_pkg::CMD_CLEAR) begin
      wr_nxt = '0;
      rd_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_inc] <= push.value;
    end
    if (do_pop) begin
      rd_data_r <= mem[rd_inc];
      pop_hit_r <= pop_hit;
    end
  end

  assign pop_value = pop_hit_r ? rd_data_r : '0;

endmodule

// ----- rtl/core/pulse_width_capture_fifo.sv -----
// top level: config registers, result stage and output skid register
// an accepted request goes to the result stage, then to the output register driving out_valid
// throughput: one request per cycle unless the output stalls; set by the counter and ring update
// a second result register lets a request be taken while an earlier result waits
// reset (synchronous, rst_n low): counters, ring indices and config go to defaults,
// ring contents are left as they are and are never read before being written
module pulse_width_capture_fifo #(
  parameter int unsigned RING_DEPTH  = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_cmd,
  input  logic                                in_line_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pwcf_pkg::VALUE_W-1:0] out_read_value,
  input  logic                                cfg_we,
  input  logic [pwcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwcf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  pwcf_pkg::cfg_t               cfg_r;
  pwcf_pkg::cmd_t               cmd;
  pwcf_pkg::ring_push_t         push;
  logic                         accept;
  logic [pwcf_pkg::VALUE_W-1:0] meas_result;
  logic [pwcf_pkg::VALUE_W-1:0] pop_value;

  logic                         a_valid_r;
  logic                         a_pop_r;
  logic [pwcf_pkg::VALUE_W-1:0] a_val_r;
  logic [pwcf_pkg::VALUE_W-1:0] a_data;
  logic                         a_adv;
  logic                         out_valid_r;
  logic [pwcf_pkg::VALUE_W-1:0] out_value_r;

  assign cmd    = pwcf_pkg::cmd_t'(in_cmd);
  assign a_adv  = !out_valid_r || out_ready;
  assign in_ready = !a_valid_r || a_adv;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b0;
      cfg_r.space_limit     <= pwcf_pkg::SPACE_LIMIT_RST;
      cfg_r.quiet_ticks     <= pwcf_pkg::QUIET_TICKS_RST;
      cfg_r.min_pulse_ticks <= pwcf_pkg::MIN_PULSE_RST;
    end else if (cfg_we) begin
      unique case (pwcf_pkg::reg_idx_t'(cfg_index))
        pwcf_pkg::REG_ENABLE:      cfg_r.enable <= cfg_wdata[0];
        pwcf_pkg::REG_SPACE_LIMIT: cfg_r.space_limit <= cfg_wdata[pwcf_pkg::LIMIT_W-1:0];
        pwcf_pkg::REG_QUIET_TICKS: cfg_r.quiet_ticks <= cfg_wdata[pwcf_pkg::LIMIT_W-1:0];
        pwcf_pkg::REG_MIN_PULSE:   cfg_r.min_pulse_ticks <= cfg_wdata[pwcf_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  pwcf_meas #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_meas (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (cmd),
    .line_level (in_line_level),
    .cfg        (cfg_r),
    .result     (meas_result),
    .push       (push)
  );

  pwcf_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (cmd),
    .push      (push),
    .pop_value (pop_value)
  );

  // pop data comes out of the ring's read register
  assign a_data = a_pop_r ? pop_value : a_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pop_r <= (cmd == pwcf_pkg::CMD_POP);
      a_val_r <= meas_result;
    end
    if (a_adv && a_valid_r) begin
      out_value_r <= a_data;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !a_valid_r && !out_valid_r)
    else $error("result stages not empty after reset");

  a_refuse_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> a_valid_r && out_valid_r)
    else $error("request refused while a result register is free");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> a_valid_r)
    else $error("accepted request left no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_adv |=> a_valid_r && $stable(a_val_r) && $stable(a_pop_r))
    else $error("stalled result stage changed");

endmodule
